>>> rtl/keyed_quantity_table_core_defines.svh
// Assertion macros used by the keyed quantity table core RTL.
`ifndef KEYED_QUANTITY_TABLE_CORE_DEFINES_SVH
`define KEYED_QUANTITY_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define KQT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("kqt assertion failed");
// Check that a trigger is followed by a consequence in the next cycle.
`define KQT_ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("kqt assertion failed");
`else
`define KQT_ASSERT(lbl, clk, rst_n, prop)
`define KQT_ASSERT_NEXT(lbl, clk, rst_n, trig, cons)
`endif

`endif

>>> rtl/kqt_pkg.sv
// Types, constants and helpers of the keyed quantity table.
package kqt_pkg;

    // Table depth and derived widths
    localparam int CAPACITY = 128;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SLOT_W   = 7;
    localparam int DATA_W   = 32;

    // Request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_SEARCH = 2'd1;
    localparam logic [1:0] REQ_UPDATE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] part_key;
        logic signed [DATA_W-1:0] amount;
    } t_request;

    typedef struct packed {
        t_status                  status;
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] quantity_out;
    } t_result;

    // Report the low slot bits of a table index, zero extended when narrower
    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [SLOT_W+IDX_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

>>> rtl/keyed_quantity_table_core.sv
// Keyed quantity table: linear key scan over a key/quantity memory pair.
// Flow: the request is latched, key entries are read from slot 0 upward and compared with
// the request key; o_done (registered) rises after a hit, after the scan runs out, or on a
// skip (a full-table insert or an unused request code). Throughput: one request at a time;
// each request scans the key memory one entry per cycle through its single registered read port.
// Reset (synchronous, active low) empties the table by clearing the fill count only.
`include "keyed_quantity_table_core_defines.svh"

module keyed_quantity_table_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  kqt_pkg::t_request  i_req,
    output logic               busy,
    output logic               o_done,
    output kqt_pkg::t_result   o_res
);
    import kqt_pkg::*;

    // Control registers
    t_state           r_state,   n_state;
    logic [CNT_W-1:0] r_addr,    n_addr;
    logic             r_cmp_vld, n_cmp_vld;
    logic [CNT_W-1:0] r_count,   n_count;
    logic             r_done,    n_done;

    // Payload registers
    t_request         r_req,     n_req;
    logic [IDX_W-1:0] r_cmp_idx, n_cmp_idx;
    t_result          r_res,     n_res;

    // Memory ports
    logic [DATA_W-1:0] key_mem [CAPACITY];
    logic [DATA_W-1:0] qty_mem [CAPACITY];
    logic [DATA_W-1:0] r_key_rd;
    logic [DATA_W-1:0] r_qty_rd;
    logic [IDX_W-1:0]  rd_addr;
    logic              key_we;
    logic              qty_we;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] key_wd;
    logic [DATA_W-1:0] qty_wd;

    logic              issue;
    logic              hit;
    logic              skip;
    logic [DATA_W-1:0] qty_sum;

    assign rd_addr = r_addr[IDX_W-1:0];
    assign issue   = (r_addr < r_count);
    assign hit     = r_cmp_vld && (r_key_rd == r_req.part_key);
    assign qty_sum = r_qty_rd + r_req.amount;
    assign skip    = ((r_req.req_type == REQ_INSERT) && (r_count == CNT_W'(CAPACITY)))
                     || ((r_req.req_type != REQ_INSERT) && (r_req.req_type != REQ_SEARCH)
                         && (r_req.req_type != REQ_UPDATE));

    // Key and quantity memories: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[wr_addr] <= key_wd;
        end
        if (qty_we) begin
            qty_mem[wr_addr] <= qty_wd;
        end
        r_key_rd <= key_mem[rd_addr];
        r_qty_rd <= qty_mem[rd_addr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_addr    <= '0;
            r_cmp_vld <= 1'b0;
            r_count   <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_cmp_vld <= n_cmp_vld;
            r_count   <= n_count;
            r_done    <= n_done;
        end
    end

    // Payload state
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_cmp_idx <= n_cmp_idx;
        r_res     <= n_res;
    end

    // Scan sequencer: issue reads, compare them in the next cycle, finish on a skip, a hit or exhaustion
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_cmp_vld = 1'b0;
        n_count   = r_count;
        n_done    = 1'b0;
        n_req     = r_req;
        n_cmp_idx = rd_addr;
        n_res     = r_res;
        key_we    = 1'b0;
        qty_we    = 1'b0;
        wr_addr   = r_cmp_idx;
        key_wd    = r_req.part_key;
        qty_wd    = r_req.amount;

        unique case (r_state)
            S_IDLE: begin
                // Latch the request beat and restart the scan
                if (start) begin
                    n_req   = i_req;
                    n_addr  = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // Advance the read pointer while entries remain
                n_cmp_vld = issue;
                if (issue) begin
                    n_addr = r_addr + CNT_W'(1);
                end

                priority if (skip) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    n_res   = '0;
                    n_res.status = (r_req.req_type == REQ_INSERT) ? ST_FULL : ST_NOT_FOUND;
                end else if (hit) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    n_res   = '0;
                    unique case (r_req.req_type)
                        REQ_INSERT: begin
                            n_res.status = ST_DUPLICATE;
                        end
                        REQ_SEARCH: begin
                            n_res.status       = ST_OK;
                            n_res.slot         = to_slot(r_cmp_idx);
                            n_res.quantity_out = r_qty_rd;
                        end
                        REQ_UPDATE: begin
                            qty_we             = 1'b1;
                            qty_wd             = qty_sum;
                            n_res.status       = ST_OK;
                            n_res.slot         = to_slot(r_cmp_idx);
                            n_res.quantity_out = qty_sum;
                        end
                        default: begin
                            n_res.status = ST_NOT_FOUND;
                        end
                    endcase
                end else if (!r_cmp_vld && !issue) begin
                    // Scan exhausted without a match
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    n_res   = '0;
                    if (r_req.req_type == REQ_INSERT) begin
                        key_we             = 1'b1;
                        qty_we             = 1'b1;
                        wr_addr            = r_count[IDX_W-1:0];
                        n_count            = r_count + CNT_W'(1);
                        n_res.status       = ST_OK;
                        n_res.slot         = to_slot(r_count[IDX_W-1:0]);
                        n_res.quantity_out = r_req.amount;
                    end else begin
                        n_res.status = ST_NOT_FOUND;
                    end
                end else begin
                    n_state = S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    // Checks
    `KQT_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY))
    `KQT_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `KQT_ASSERT(a_done_after_scan, i_clk, i_rst_n, !o_done || $past(r_state == S_SCAN))
    `KQT_ASSERT(a_fail_zero, i_clk, i_rst_n,
        !(o_done && o_res.status != ST_OK) || (o_res.slot == '0 && o_res.quantity_out == '0))
    `KQT_ASSERT(a_count_on_insert, i_clk, i_rst_n,
        r_count == $past(r_count) || (o_done && o_res.status == ST_OK))

endmodule
